// ===== rtl/mdma_pkg.sv =====
// ============================================================================
// mdma_pkg: shared types and constants of the four-channel DMA controller
// Command codes, register offsets, item and result records, control and address helpers.
// ============================================================================
package mdma_pkg;

    typedef enum logic [2:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_LINE  = 3'd2,
        CMD_INTR  = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    localparam logic [5:0] GC_OFFSET = 6'h3e;
    localparam logic [3:0] R_SRC_HI  = 4'h0;
    localparam logic [3:0] R_SRC_LO  = 4'h2;
    localparam logic [3:0] R_DST_HI  = 4'h4;
    localparam logic [3:0] R_DST_LO  = 4'h6;
    localparam logic [3:0] R_CNT_HI  = 4'h8;
    localparam logic [3:0] R_CNT_LO  = 4'ha;
    localparam logic [3:0] R_CTRL    = 4'hc;

    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;

    // One input item as held in the queue between front and back
    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  reg_offset;
        logic        access_halfword;
        logic [15:0] write_data;
        logic [1:0]  line_channel;
        logic        line_level;
        logic [2:0]  internal_source;
    } item_t;

    // Result record (packed into the output tdata)
    typedef struct packed {
        logic        setup_error;
        logic        irq_pulse;
        logic        tc_pulse;
        logic [3:0]  ack_lines;
        logic [2:0]  xfer_bytes;
        logic [31:0] xfer_dest;
        logic [31:0] xfer_source;
        logic [1:0]  xfer_channel;
        logic        xfer_valid;
        logic [15:0] read_data;
    } result_t;

    function automatic logic ctrl_ok(input logic [15:0] c);
        return (c[14:12] != 3'd2) && (c[14:12] != 3'd3) && (c[11:10] != 2'd3) &&
               (c[9:8] != 2'd3) && (c[7:6] != 2'd3) && (c[2:1] != 2'd3);
    endfunction

    function automatic logic in_internal(input logic [31:0] a);
        return (a[31:12] == 20'd0) || (a[31:12] == 20'hfe000) ||
               (a[31:10] == 22'h300000);
    endfunction

    function automatic logic [31:0] step_addr(input logic [31:0] a,
                                              input logic [1:0] dir,
                                              input logic [31:0] w);
        logic [31:0] r;
        r = a;
        if (dir == DIR_UP)
            r = a + w;
        else if (dir == DIR_DOWN)
            r = a - w;
        return r;
    endfunction

endpackage

// ===== rtl/mdma_queue.sv =====
// ============================================================================
// mdma_queue: two-entry item queue
// Decouples the front (input acceptance) from the back (execution).
// ============================================================================
module mdma_queue
    import mdma_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic push;
    logic pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/mdma_exec.sv =====
// ============================================================================
// mdma_exec: execution back end
// Holds the channel registers, runs register accesses, request events and
// ticks, one item per cycle unless the output stalls, into an output register.
// ============================================================================
module mdma_exec
    import mdma_pkg::*;
#(
    parameter int CHANNELS         = 4,
    parameter int INTERNAL_SOURCES = 8,
    parameter int EXTERNAL_CODE    = 0,
    parameter int SOFTWARE_CODE    = 1
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam logic [2:0] EXT_C = 3'(EXTERNAL_CODE);
    localparam logic [2:0] SW_C  = 3'(SOFTWARE_CODE);

    logic [31:0] src_reg  [4];
    logic [31:0] dst_reg  [4];
    logic [23:0] cnt_reg  [4];
    logic [15:0] ctrl_reg [4];
    logic [3:0]  ext_req_reg;
    logic [3:0]  soft_req_reg;
    logic [7:0]  int_pend_reg;
    logic [8:0]  gc_reg;
    logic        valid_reg;
    result_t     res_reg;

    logic [31:0] src_next  [4];
    logic [31:0] dst_next  [4];
    logic [23:0] cnt_next  [4];
    logic [15:0] ctrl_next [4];
    logic [3:0]  ext_req_next;
    logic [3:0]  soft_req_next;
    logic [7:0]  int_pend_next;
    logic [8:0]  gc_next;
    result_t     res_next;

    logic        fire;
    logic [3:0]  req_vec;
    logic        sel_found;
    logic [1:0]  sel;
    logic [1:0]  ch;
    logic [3:0]  r;
    logic [15:0] c;
    logic [2:0]  tt;
    logic [31:0] w;
    logic [23:0] cnt;
    logic [23:0] cnt_dec;
    logic        first;

    assign in_ready   = !valid_reg || out_ready;
    assign fire       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = res_reg;

    // Per-channel request flags
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [2:0] t;
            t = ctrl_reg[i][14:12];
            req_vec[i] = 1'b0;
            if (i < CHANNELS && ctrl_reg[i][0] && ctrl_ok(ctrl_reg[i]))
            begin
                if (t == EXT_C)
                    req_vec[i] = ext_req_reg[i];
                else if (t == SW_C)
                    req_vec[i] = soft_req_reg[i];
                else
                    req_vec[i] = (32'(t) < INTERNAL_SOURCES) && int_pend_reg[t];
            end
        end
    end

    // Lowest requested channel
    always_comb
    begin
        sel_found = |req_vec;
        priority casez (req_vec)
            4'b???1: sel = 2'd0;
            4'b??10: sel = 2'd1;
            4'b?100: sel = 2'd2;
            default: sel = 2'd3;
        endcase
    end

    // Item execution
    always_comb
    begin
        logic tick_sel;
        for (int i = 0; i < 4; i++)
        begin
            src_next[i]  = src_reg[i];
            dst_next[i]  = dst_reg[i];
            cnt_next[i]  = cnt_reg[i];
            ctrl_next[i] = ctrl_reg[i];
        end
        ext_req_next  = ext_req_reg;
        soft_req_next = soft_req_reg;
        int_pend_next = int_pend_reg;
        gc_next       = gc_reg;
        res_next      = '0;
        tick_sel      = 1'b0;

        ch      = in_item.reg_offset[5:4];
        r       = in_item.reg_offset[3:0];
        c       = ctrl_reg[sel];
        tt      = c[14:12];
        w       = 32'd1 << c[2:1];
        cnt     = cnt_reg[sel];
        cnt_dec = cnt - w[23:0];
        first   = (cnt == 24'd0);

        unique case (in_item.command)
            CMD_READ:
            begin
                if (in_item.access_halfword)
                begin
                    if (in_item.reg_offset == GC_OFFSET)
                    begin
                        res_next.read_data = {7'd0, gc_reg};
                        gc_next[7:4] = 4'd0;
                    end
                    else if (32'(ch) < CHANNELS)
                    begin
                        unique case (r)
                            R_SRC_HI: res_next.read_data = src_reg[ch][31:16];
                            R_SRC_LO: res_next.read_data = src_reg[ch][15:0];
                            R_DST_HI: res_next.read_data = dst_reg[ch][31:16];
                            R_DST_LO: res_next.read_data = dst_reg[ch][15:0];
                            R_CNT_HI: res_next.read_data = {8'd0, cnt_reg[ch][23:16]};
                            R_CNT_LO: res_next.read_data = cnt_reg[ch][15:0];
                            R_CTRL:   res_next.read_data = ctrl_reg[ch];
                            default:  res_next.read_data = 16'd0;
                        endcase
                    end
                end
            end
            CMD_WRITE:
            begin
                if (in_item.access_halfword)
                begin
                    if (in_item.reg_offset == GC_OFFSET)
                    begin
                        gc_next[0] = in_item.write_data[0];
                        gc_next[8] = in_item.write_data[8];
                    end
                    else if (32'(ch) < CHANNELS)
                    begin
                        unique case (r)
                            R_SRC_HI: src_next[ch][31:16] = in_item.write_data;
                            R_SRC_LO: src_next[ch][15:0]  = in_item.write_data;
                            R_DST_HI: dst_next[ch][31:16] = in_item.write_data;
                            R_DST_LO: dst_next[ch][15:0]  = in_item.write_data;
                            R_CNT_HI: cnt_next[ch][23:16] = in_item.write_data[7:0];
                            R_CNT_LO: cnt_next[ch][15:0]  = in_item.write_data;
                            R_CTRL:
                            begin
                                ctrl_next[ch] = in_item.write_data;
                                soft_req_next[ch] = (in_item.write_data[14:12] == SW_C);
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_LINE:
            begin
                if (32'(in_item.line_channel) < CHANNELS)
                    ext_req_next[in_item.line_channel] = in_item.line_level ^
                        ctrl_reg[in_item.line_channel][4];
            end
            CMD_INTR:
            begin
                if (32'(in_item.internal_source) < INTERNAL_SOURCES)
                    int_pend_next[in_item.internal_source] = 1'b1;
            end
            CMD_TICK:
            begin
                if (gc_reg[0] && sel_found)
                begin
                    tick_sel = 1'b1;
                    res_next.xfer_channel = sel;
                    if ((!first && cnt < w[23:0]) || in_internal(src_reg[sel]) ||
                        in_internal(dst_reg[sel]))
                    begin
                        ctrl_next[sel][0] = 1'b0;
                        res_next.setup_error = 1'b1;
                    end
                    else
                    begin
                        res_next.xfer_valid  = 1'b1;
                        res_next.xfer_source = src_reg[sel];
                        res_next.xfer_dest   = dst_reg[sel];
                        res_next.xfer_bytes  = w[2:0];
                        src_next[sel] = step_addr(src_reg[sel], c[9:8], w);
                        dst_next[sel] = step_addr(dst_reg[sel], c[7:6], w);
                        if (!first)
                            cnt_next[sel] = cnt_dec;
                        if (first || cnt_dec == 24'd0)
                        begin
                            ctrl_next[sel][0] = 1'b0;
                            gc_next[4 + 32'(sel)] = 1'b1;
                            res_next.tc_pulse  = 1'b1;
                            res_next.irq_pulse = 1'b1;
                        end
                    end
                    if (tt == EXT_C)
                    begin
                        if (!c[3])
                            ext_req_next[sel] = 1'b0;
                    end
                    else if (tt == SW_C)
                        soft_req_next[sel] = 1'b0;
                    else if (32'(tt) < INTERNAL_SOURCES)
                        int_pend_next[tt] = 1'b0;
                end
            end
            default: ;
        endcase

        // Ack levels from the control words as they stand after this item
        for (int i = 0; i < 4; i++)
        begin
            if (i < CHANNELS)
                res_next.ack_lines[i] = (tick_sel && sel == 2'(i)) ?
                    ctrl_next[i][5] : ~ctrl_next[i][5];
            else
                res_next.ack_lines[i] = 1'b1;
        end
    end

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src_reg[i]  <= '0;
                dst_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                ctrl_reg[i] <= '0;
            end
            ext_req_reg  <= '0;
            soft_req_reg <= '0;
            int_pend_reg <= '0;
            gc_reg       <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    src_reg[i]  <= src_next[i];
                    dst_reg[i]  <= dst_next[i];
                    cnt_reg[i]  <= cnt_next[i];
                    ctrl_reg[i] <= ctrl_next[i];
                end
                ext_req_reg  <= ext_req_next;
                soft_req_reg <= soft_req_next;
                int_pend_reg <= int_pend_next;
                gc_reg       <= gc_next;
                valid_reg    <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

endmodule

// ===== rtl/multichannel_dma_controller_core.sv =====
// ============================================================================
// multichannel_dma_controller_core: four-channel DMA controller
// Front takes items into a short queue; back end executes them in order.
//
//  channel | direction | tdata fields (low bit first)
//  s_axis  | in        | command, reg_offset, access_halfword, write_data,
//          |           | line_channel, line_level, internal_source
//  m_axis  | out       | read_data, xfer_valid, xfer_channel, xfer_source,
//          |           | xfer_dest, xfer_bytes, ack_lines, tc_pulse,
//          |           | irq_pulse, setup_error
//
// One item per cycle sustained while the output is not stalled; an item passes the queue and the result register.
// The execute stage (priority pick, address adders, count
// subtract) sets the rate.
// Reset clears all channel registers, request flags and the queue.
// A stalled output holds its result; the queue absorbs two items behind it.
// ============================================================================
module multichannel_dma_controller_core
    import mdma_pkg::*;
#(
    parameter int CHANNELS         = 4,
    parameter int INTERNAL_SOURCES = 8,
    parameter int EXTERNAL_CODE    = 0,
    parameter int SOFTWARE_CODE    = 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, reg_offset, access_halfword, write_data, line_channel,
    // line_level, internal_source
    input  logic [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_data, xfer_valid, xfer_channel, xfer_source, xfer_dest,
    // xfer_bytes, ack_lines, tc_pulse, irq_pulse, setup_error, zero fill
    output logic [103:0] m_axis_tdata
);

    item_t   in_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_ready;
    result_t result;

    // Front: unpack the item fields
    assign in_item.command         = s_axis_tdata[2:0];
    assign in_item.reg_offset      = s_axis_tdata[8:3];
    assign in_item.access_halfword = s_axis_tdata[9];
    assign in_item.write_data      = s_axis_tdata[25:10];
    assign in_item.line_channel    = s_axis_tdata[27:26];
    assign in_item.line_level      = s_axis_tdata[28];
    assign in_item.internal_source = s_axis_tdata[31:29];

    mdma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    mdma_exec #(
        .CHANNELS         (CHANNELS),
        .INTERNAL_SOURCES (INTERNAL_SOURCES),
        .EXTERNAL_CODE    (EXTERNAL_CODE),
        .SOFTWARE_CODE    (SOFTWARE_CODE)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {7'd0, result};

    // Checks
    a_xfer_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && result.xfer_valid |->
            (result.xfer_bytes == 3'd1 || result.xfer_bytes == 3'd2 ||
             result.xfer_bytes == 3'd4))
        else $error("transfer with bad unit size");
    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(result.setup_error && result.xfer_valid))
        else $error("setup error together with a transfer");
    a_tc_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && result.tc_pulse |-> result.xfer_valid && result.irq_pulse)
        else $error("terminal count without transfer");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

// ===== bench/multichannel_dma_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// multichannel_dma_controller_core_tb: self-checking bench of the DMA core
// Walks a table of directed items, then random channel programming bursts
// and noise items. Every accepted item is run through an in-bench model
// of the channels and the result stream is compared item by item.
// ============================================================================
module multichannel_dma_controller_core_tb;
    import mdma_pkg::*;

    localparam int  LIMIT      = 400000;
    localparam int  ITEM_GOAL  = 1700;

    typedef struct {
        logic [31:0] data;
        bit          typed;
        result_t     res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    // Channel state mirror
    logic [31:0] src_q [4];
    logic [31:0] dst_q [4];
    logic [23:0] cnt_q [4];
    logic [15:0] ctl_q [4];
    logic        line_req [4];
    logic        sw_req [4];
    logic        int_req [8];
    logic [8:0]  gctl;

    result_t     pending_res [$];
    row_t        dir_rows [$];
    int          src_idle;
    int          snk_stall;
    int          n_sent;
    int          n_mismatch;
    int          cycles;

    multichannel_dma_controller_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] pack_item(input cmd_t cmd, input logic [5:0] off,
                                              input logic half, input logic [15:0] wd,
                                              input logic [1:0] lch, input logic lvl,
                                              input logic [2:0] isrc);
        return {isrc, lvl, lch, wd, half, off, 3'(cmd)};
    endfunction

    function automatic logic ctl_valid(input logic [15:0] c);
        logic bad;
        bad = (c[14:13] == 2'b01) || (&c[11:10]) || (&c[9:8]) || (&c[7:6]) || (&c[2:1]);
        return !bad;
    endfunction

    function automatic logic addr_reserved(input logic [31:0] a);
        return (a < 32'h0000_1000) || (a >= 32'hfe00_0000 && a < 32'hfe00_1000) ||
               (a >= 32'hc000_0000 && a < 32'hc000_0400);
    endfunction

    function automatic logic [31:0] addr_next(input logic [31:0] a, input logic [1:0] dir,
                                              input logic [31:0] w);
        if (dir == 2'd0)
            return a + w;
        if (dir == 2'd1)
            return a - w;
        return a;
    endfunction

    function automatic logic chan_requested(input int i);
        logic [15:0] c;
        c = ctl_q[i];
        if (!c[0] || !ctl_valid(c))
            return 1'b0;
        if (c[14:12] == 3'd0)
            return line_req[i];
        if (c[14:12] == 3'd1)
            return sw_req[i];
        return int_req[c[14:12]];
    endfunction

    // Apply one item to the mirror and return what the core should emit
    task automatic dma_step(input logic [31:0] d, output result_t r);
        logic [2:0]  cmd;
        logic [5:0]  off;
        logic        half;
        logic [15:0] wd;
        logic [1:0]  lch;
        logic        lvl;
        logic [2:0]  isrc;
        logic [1:0]  ch;
        logic [15:0] c;
        logic [31:0] w;
        logic [23:0] cnt;
        logic        first;
        int          sel;
        cmd  = d[2:0];
        off  = d[8:3];
        half = d[9];
        wd   = d[25:10];
        lch  = d[27:26];
        lvl  = d[28];
        isrc = d[31:29];
        sel  = -1;
        r    = '0;
        ch   = off[5:4];
        case (cmd)
            CMD_READ:
                if (half) begin
                    if (off == GC_OFFSET) begin
                        r.read_data = 16'(gctl);
                        gctl = gctl & 9'h10f;
                    end
                    else begin
                        case (off[3:0])
                            R_SRC_HI: r.read_data = src_q[ch][31:16];
                            R_SRC_LO: r.read_data = src_q[ch][15:0];
                            R_DST_HI: r.read_data = dst_q[ch][31:16];
                            R_DST_LO: r.read_data = dst_q[ch][15:0];
                            R_CNT_HI: r.read_data = 16'(cnt_q[ch][23:16]);
                            R_CNT_LO: r.read_data = cnt_q[ch][15:0];
                            R_CTRL:   r.read_data = ctl_q[ch];
                            default:  r.read_data = 16'h0;
                        endcase
                    end
                end
            CMD_WRITE:
                if (half) begin
                    if (off == GC_OFFSET)
                        gctl = (gctl & 9'h0f0) | (wd[8:0] & 9'h101);
                    else begin
                        case (off[3:0])
                            R_SRC_HI: src_q[ch][31:16] = wd;
                            R_SRC_LO: src_q[ch][15:0]  = wd;
                            R_DST_HI: dst_q[ch][31:16] = wd;
                            R_DST_LO: dst_q[ch][15:0]  = wd;
                            R_CNT_HI: cnt_q[ch][23:16] = wd[7:0];
                            R_CNT_LO: cnt_q[ch][15:0]  = wd;
                            R_CTRL: begin
                                ctl_q[ch]  = wd;
                                sw_req[ch] = (wd[14:12] == 3'd1);
                            end
                            default: ;
                        endcase
                    end
                end
            CMD_LINE:
                line_req[lch] = ctl_q[lch][4] ? ~lvl : lvl;
            CMD_INTR:
                int_req[isrc] = 1'b1;
            CMD_TICK:
                if (gctl[0]) begin
                    for (int i = 3; i >= 0; i--)
                        if (chan_requested(i))
                            sel = i;
                    if (sel >= 0) begin
                        ch    = 2'(sel);
                        c     = ctl_q[ch];
                        w     = 32'd1 << c[2:1];
                        cnt   = cnt_q[ch];
                        first = (cnt == 24'd0);
                        r.xfer_channel = ch;
                        if ((!first && 32'(cnt) < w) || addr_reserved(src_q[ch]) ||
                            addr_reserved(dst_q[ch])) begin
                            ctl_q[ch][0]  = 1'b0;
                            r.setup_error = 1'b1;
                        end
                        else begin
                            r.xfer_valid  = 1'b1;
                            r.xfer_source = src_q[ch];
                            r.xfer_dest   = dst_q[ch];
                            r.xfer_bytes  = w[2:0];
                            src_q[ch] = addr_next(src_q[ch], c[9:8], w);
                            dst_q[ch] = addr_next(dst_q[ch], c[7:6], w);
                            if (!first)
                                cnt_q[ch] = cnt - w[23:0];
                            if (first || cnt_q[ch] == 24'd0) begin
                                ctl_q[ch][0]  = 1'b0;
                                gctl[4 + ch]  = 1'b1;
                                r.tc_pulse    = 1'b1;
                                r.irq_pulse   = 1'b1;
                            end
                        end
                        // consume the request that started this unit
                        if (c[14:12] == 3'd0) begin
                            if (!c[3])
                                line_req[ch] = 1'b0;
                        end
                        else if (c[14:12] == 3'd1)
                            sw_req[ch] = 1'b0;
                        else
                            int_req[c[14:12]] = 1'b0;
                    end
                end
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
            r.ack_lines[i] = (i == sel) ? ctl_q[i][5] : ~ctl_q[i][5];
    endtask

    // Drive one item, wait for acceptance, then queue what it should produce
    task automatic send_item(input logic [31:0] d, input bit typed, input result_t tres);
        result_t r;
        while ($urandom_range(0, 99) < src_idle) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        dma_step(d, r);
        pending_res.push_back(typed ? tres : r);
        n_sent++;
    endtask

    task automatic send(input logic [31:0] d);
        send_item(d, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [31:0] d, input bit typed, input result_t r);
        row_t row;
        row.data  = d;
        row.typed = typed;
        row.res   = r;
        dir_rows.push_back(row);
    endtask

    function automatic logic [15:0] rand_hi_addr();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hfe00;
            2:       return 16'hc000;
            default: return 16'($urandom_range(16'h0001, 16'hffff));
        endcase
    endfunction

    // Control word: mostly a valid, enabled setup with random options
    function automatic logic [15:0] rand_ctl();
        logic [15:0] c;
        logic [2:0]  kinds [6] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
        if ($urandom_range(0, 19) == 0)
            return 16'($urandom());
        c        = 16'h0;
        c[0]     = ($urandom_range(0, 9) != 0);
        c[2:1]   = 2'($urandom_range(0, 2));
        c[5:3]   = 3'($urandom());
        c[7:6]   = 2'($urandom_range(0, 2));
        c[9:8]   = 2'($urandom_range(0, 2));
        c[11:10] = 2'($urandom_range(0, 2));
        c[14:12] = kinds[$urandom_range(0, 5)];
        c[15]    = 1'($urandom());
        return c;
    endfunction

    // Raise the request that the control word listens to
    task automatic raise_request(input logic [1:0] ch, input logic [15:0] c);
        if (c[14:12] == 3'd0)
            send(pack_item(CMD_LINE, 6'h0, 1'b0, 16'h0, ch, ~c[4], 3'h0));
        else if (c[14:12] == 3'd1)
            send(pack_item(CMD_WRITE, {ch, R_CTRL}, 1'b1, c, 2'h0, 1'b0, 3'h0));
        else
            send(pack_item(CMD_INTR, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, c[14:12]));
    endtask

    task automatic program_burst();
        logic [1:0]  ch;
        logic [15:0] c;
        int          ticks;
        ch = 2'($urandom());
        c  = rand_ctl();
        send(pack_item(CMD_WRITE, {ch, R_SRC_HI}, 1'b1, rand_hi_addr(), 2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, {ch, R_SRC_LO}, 1'b1, 16'($urandom()), 2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, {ch, R_DST_HI}, 1'b1, rand_hi_addr(), 2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, {ch, R_DST_LO}, 1'b1, 16'($urandom()), 2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, {ch, R_CNT_HI}, 1'b1,
                       ($urandom_range(0, 15) == 0) ? 16'($urandom()) : 16'h0,
                       2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, {ch, R_CNT_LO}, 1'b1, 16'($urandom_range(0, 24)),
                       2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, {ch, R_CTRL}, 1'b1, c, 2'h0, 1'b0, 3'h0));
        send(pack_item(CMD_WRITE, GC_OFFSET, 1'b1,
                       16'($urandom()) | 16'($urandom_range(0, 9) != 0), 2'h0, 1'b0, 3'h0));
        ticks = $urandom_range(2, 10);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 2) != 0)
                raise_request(ch, c);
            send(pack_item(CMD_TICK, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, 3'h0));
        end
        if ($urandom_range(0, 1) == 1)
            send(pack_item(CMD_READ, GC_OFFSET, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0));
    endtask

    task automatic send_noise();
        logic [31:0] d;
        d = 32'($urandom());
        if ($urandom_range(0, 3) != 0)
            d[2:0] = 3'($urandom_range(0, 4));
        send(d);
    endtask

    // Result stream check
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata[92:0]);
            if (pending_res.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected item: %h", got);
            end
            else begin
                want = pending_res.pop_front();
                if (got.read_data != want.read_data || got.xfer_valid != want.xfer_valid ||
                    got.xfer_channel != want.xfer_channel ||
                    got.xfer_source != want.xfer_source ||
                    got.xfer_dest != want.xfer_dest || got.xfer_bytes != want.xfer_bytes ||
                    got.ack_lines != want.ack_lines || got.tc_pulse != want.tc_pulse ||
                    got.irq_pulse != want.irq_pulse ||
                    got.setup_error != want.setup_error) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // Receiver stall
    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall);

    // Run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        result_t idle_res;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        src_idle      = 0;
        snk_stall     = 0;
        n_sent        = 0;
        n_mismatch    = 0;
        cycles        = 0;
        for (int i = 0; i < 4; i++) begin
            src_q[i]    = '0;
            dst_q[i]    = '0;
            cnt_q[i]    = '0;
            ctl_q[i]    = '0;
            line_req[i] = 1'b0;
            sw_req[i]   = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            int_req[i] = 1'b0;
        gctl = '0;

        // nothing set up: reads give zero, all ack lines idle high
        idle_res           = '0;
        idle_res.ack_lines = 4'hf;
        add_row(pack_item(CMD_READ, GC_OFFSET, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0), 1, idle_res);
        add_row(pack_item(CMD_READ, GC_OFFSET, 1'b0, 16'h0, 2'h0, 1'b0, 3'h0), 1, idle_res);
        add_row(pack_item(CMD_READ, 6'h0e, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0), 1, idle_res);
        add_row(pack_item(CMD_TICK, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, 3'h0), 1, idle_res);
        add_row(32'hffff_fffd, 1, idle_res);
        add_row(32'hffff_ffff, 1, idle_res);
        // channel 0: top source address, zero count, 4-byte unit, soft request
        add_row(pack_item(CMD_WRITE, {2'd0, R_SRC_HI}, 1'b1, 16'hffff, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_WRITE, {2'd0, R_SRC_LO}, 1'b1, 16'hfffe, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_WRITE, {2'd0, R_DST_HI}, 1'b1, 16'h0001, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_WRITE, {2'd0, R_CNT_HI}, 1'b0, 16'hffff, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_WRITE, {2'd0, R_CTRL}, 1'b1, 16'h1065, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_WRITE, GC_OFFSET, 1'b1, 16'hffff, 2'h0, 1'b0, 3'h0), 0, '0);
        add_row(pack_item(CMD_TICK, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);
        add_row(pack_item(CMD_READ, GC_OFFSET, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);
        add_row(pack_item(CMD_READ, GC_OFFSET, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);
        add_row(pack_item(CMD_READ, {2'd0, R_SRC_LO}, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);
        add_row(pack_item(CMD_READ, {2'd0, R_CTRL}, 1'b1, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);
        // channel 1 points into reserved space: setup error
        add_row(pack_item(CMD_WRITE, {2'd1, R_SRC_HI}, 1'b1, 16'hfe00, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_WRITE, {2'd1, R_CTRL}, 1'b1, 16'h1001, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_TICK, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);
        // external line (active low) on channel 2, internal source 7 on channel 3
        add_row(pack_item(CMD_WRITE, {2'd2, R_CTRL}, 1'b1, 16'h0019, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_LINE, 6'h0, 1'b0, 16'h0, 2'd2, 1'b0, 3'h0), 0, '0);
        add_row(pack_item(CMD_WRITE, {2'd3, R_CTRL}, 1'b1, 16'h7001, 2'h0, 1'b0, 3'h0),
                0, '0);
        add_row(pack_item(CMD_INTR, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, 3'd7), 0, '0);
        add_row(pack_item(CMD_TICK, 6'h0, 1'b0, 16'h0, 2'h0, 1'b0, 3'h0), 0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].data, dir_rows[k].typed, dir_rows[k].res);
        drain();

        // random traffic through four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 84; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 84; end
                default: begin src_idle = 33; snk_stall = 33; end
            endcase
            while (n_sent < (ph + 1) * ITEM_GOAL / 4) begin
                if ($urandom_range(0, 9) < 6)
                    program_burst();
                else
                    send_noise();
            end
            drain();
        end

        src_idle  = 0;
        snk_stall = 0;
        repeat (10) @(posedge clk);
        if (n_mismatch == 0 && pending_res.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
